// ----- rtl/asc_pkg.sv -----
// Shared types and constants for the ADC sample calibrate and decimate block.
// No dependencies; every other file of the block imports this package.
package asc_pkg;

   // buffer geometry
   localparam int BUF_POINTS = 1024;
   localparam int POS_W      = $clog2(BUF_POINTS) + 2;
   localparam int PCOUNT_W   = 11;
   localparam int ADDR_W     = 10;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // commands
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_STOP   = 2'd2;

   // modes
   localparam logic [2:0] MODE_PEAK   = 3'd0;
   localparam logic [2:0] MODE_NORMAL = 3'd1;
   localparam logic [2:0] MODE_RAND   = 3'd2;
   localparam logic [2:0] MODE_DEC4   = 3'd3;
   localparam logic [2:0] MODE_DEC5   = 3'd4;

   // register indexes
   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_STRIDE    = 3'd1;
   localparam logic [2:0] REG_START_OFS = 3'd2;
   localparam logic [2:0] REG_PCOUNT    = 3'd3;
   localparam logic [2:0] REG_MIDPOINT  = 3'd4;
   localparam logic [2:0] REG_GAIN      = 3'd5;
   localparam logic [2:0] REG_BALANCE   = 3'd6;
   localparam logic [2:0] REG_ODD_START = 3'd7;

   typedef struct packed {
      logic [2:0]          mode;
      logic [7:0]          stride;
      logic signed [10:0]  start_offset;
      logic [PCOUNT_W-1:0] point_count;
      logic [7:0]          midpoint;
      logic [15:0]         gain;
      logic signed [7:0]   balance;
      logic                odd_start;
   } cfg_type;

   // writes planned for one item; slot 0 is taken first
   typedef struct packed {
      logic [1:0]        cnt;
      logic [ADDR_W-1:0] addr0;
      logic              hi0;
      logic [ADDR_W-1:0] addr1;
      logic              hi1;
      logic              done;
   } plan_type;

endpackage

// ----- rtl/asc_cal_lane.sv -----
// One calibration lane: midpoint + trunc((sample - midpoint) * gain / 2^14), clamped.
// Multiply is registered; offset and clamp follow combinationally. Uses asc_pkg.
module asc_cal_lane (
   input  logic              clock,
   input  logic              load,
   input  logic signed [9:0] sample,
   input  logic [7:0]        midpoint,
   input  logic [15:0]       gain,
   output logic [7:0]        value
);
   import asc_pkg::*;

   logic signed [9:0]  diff;
   logic [8:0]         mag;
   logic [24:0]        prod;
   logic [10:0]        q_ff;
   logic               neg_ff;
   logic signed [12:0] mid_s;
   logic signed [12:0] q_s;
   logic signed [12:0] sum;

   assign diff = sample - signed'({2'b00, midpoint});
   assign mag  = diff[9] ? 9'(-diff) : diff[8:0];
   assign prod = 25'(mag) * 25'(gain);

   // magnitude is truncated, so the sign is applied afterwards
   always_ff @(posedge clock) begin
      if (load) begin
         q_ff   <= prod[24:14];
         neg_ff <= diff[9];
      end
   end

   assign mid_s = signed'({5'b0, midpoint});
   assign q_s   = signed'({2'b0, q_ff});
   assign sum   = neg_ff ? (mid_s - q_s) : (mid_s + q_s);

   always_comb begin
      if (sum < 0) begin
         value = 8'd0;
      end else if (sum > 13'sd255) begin
         value = 8'd255;
      end else begin
         value = sum[7:0];
      end
   end

endmodule

// ----- rtl/asc_sequencer.sv -----
// Capture control: write position, discard and lead flags, word phase.
// Plans up to two buffer writes per item and registers the plan. Uses asc_pkg.
module asc_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         cmd,
   input  asc_pkg::cfg_type   cfg,
   output asc_pkg::plan_type  plan
);
   import asc_pkg::*;

   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic                    disc_ff, disc_in;
   logic                    lead_ff, lead_in;
   logic [2:0]              phase_ff, phase_in;
   logic                    active_ff, active_in;
   plan_type                plan_ff, plan_in;

   logic [PCOUNT_W-1:0]     end_pts;
   logic signed [POS_W-1:0] end_s, st_s, pos_st, pos_st2, pos_one;
   logic                    below_end;
   logic [2:0]              ph5;
   logic                    c0_v, c0_hi, c1_v, c1_hi, e0, e1;
   logic signed [POS_W-1:0] c0_pos, c1_pos;

   assign end_pts   = (cfg.point_count < PCOUNT_W'(BUF_POINTS)) ? cfg.point_count
                                                                : PCOUNT_W'(BUF_POINTS);
   assign end_s     = signed'({{(POS_W-PCOUNT_W){1'b0}}, end_pts});
   assign st_s      = signed'({{(POS_W-8){1'b0}}, cfg.stride});
   assign pos_st    = pos_ff + st_s;
   assign pos_st2   = pos_st + st_s;
   assign pos_one   = pos_ff + POS_W'(1);
   assign below_end = pos_ff < end_s;

   always_comb begin
      case (phase_ff)
         3'd5:    ph5 = 3'd0;
         3'd6:    ph5 = 3'd1;
         3'd7:    ph5 = 3'd2;
         default: ph5 = phase_ff;
      endcase
   end

   always_comb begin
      pos_in    = pos_ff;
      disc_in   = disc_ff;
      lead_in   = lead_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      c0_v      = 1'b0;
      c0_pos    = pos_ff;
      c0_hi     = 1'b0;
      c1_v      = 1'b0;
      c1_pos    = pos_one;
      c1_hi     = 1'b1;
      if (accept) begin
         case (cmd)
            CMD_START: begin
               pos_in    = (cfg.mode == MODE_PEAK) ? '0
                         : {{(POS_W-11){cfg.start_offset[10]}}, cfg.start_offset};
               disc_in   = 1'b1;
               lead_in   = (cfg.mode == MODE_NORMAL) && !cfg.odd_start;
               phase_in  = 3'd0;
               active_in = 1'b1;
            end
            CMD_STOP: begin
               active_in = 1'b0;
            end
            CMD_SAMPLE: begin
               if (active_ff && disc_ff) begin
                  disc_in = 1'b0;
               end else if (active_ff) begin
                  case (cfg.mode)
                     MODE_PEAK: begin
                        if (below_end) begin
                           c0_v   = 1'b1;
                           c1_v   = 1'b1;
                           pos_in = pos_ff + POS_W'(2);
                        end
                     end
                     MODE_NORMAL: begin
                        if (lead_ff) begin
                           lead_in = 1'b0;
                           c0_v    = 1'b1;
                           c0_hi   = 1'b1;
                           pos_in  = pos_st;
                        end else if (below_end) begin
                           c0_v   = 1'b1;
                           c1_v   = 1'b1;
                           c1_pos = pos_st;
                           pos_in = pos_st2;
                        end
                     end
                     MODE_RAND: begin
                        if (pos_ff[POS_W-1]) begin
                           pos_in = pos_st;
                        end else if (below_end) begin
                           c0_v   = 1'b1;
                           pos_in = pos_st;
                        end
                     end
                     MODE_DEC4: begin
                        if (phase_ff[0]) begin
                           phase_in = 3'd0;
                        end else if (below_end) begin
                           c0_v     = 1'b1;
                           pos_in   = pos_st;
                           phase_in = 3'd1;
                        end
                     end
                     MODE_DEC5: begin
                        if (ph5 == 3'd0) begin
                           if (below_end) begin
                              c0_v     = 1'b1;
                              pos_in   = pos_st;
                              phase_in = 3'd1;
                           end else begin
                              phase_in = 3'd0;
                           end
                        end else begin
                           if ((ph5 == 3'd2) && below_end) begin
                              c0_v   = 1'b1;
                              c0_hi  = 1'b1;
                              pos_in = pos_st;
                           end
                           phase_in = (ph5 == 3'd4) ? 3'd0 : ph5 + 3'd1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // drop writes outside the buffer, then pack survivors into slot 0 first
   assign e0 = c0_v && !c0_pos[POS_W-1] && (c0_pos < end_s);
   assign e1 = c1_v && !c1_pos[POS_W-1] && (c1_pos < end_s);

   always_comb begin
      plan_in.cnt   = 2'(e0) + 2'(e1);
      plan_in.addr0 = e0 ? c0_pos[ADDR_W-1:0] : c1_pos[ADDR_W-1:0];
      plan_in.hi0   = e0 ? c0_hi : c1_hi;
      plan_in.addr1 = c1_pos[ADDR_W-1:0];
      plan_in.hi1   = c1_hi;
      plan_in.done  = pos_in >= end_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         disc_ff   <= 1'b0;
         lead_ff   <= 1'b0;
         phase_ff  <= 3'd0;
         active_ff <= 1'b0;
         plan_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         disc_ff   <= disc_in;
         lead_ff   <= lead_in;
         phase_ff  <= phase_in;
         active_ff <= active_in;
         plan_ff   <= plan_in;
      end
   end

   assign plan = plan_ff;

endmodule

// ----- rtl/asc_merge.sv -----
// Merge stage: picks the low or high lane value for each planned write and
// queues the writes for the result channel. Uses asc_pkg.
module asc_merge (
   input  logic                       clock,
   input  logic                       reset,
   input  asc_pkg::plan_type          plan,
   input  logic [7:0]                 lo_value,
   input  logic [7:0]                 hi_value,
   output logic                       room,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [asc_pkg::ADDR_W-1:0] rsp_address,
   output logic [7:0]                 rsp_value,
   output logic                       rsp_last,
   output logic                       rsp_capture_done
);
   import asc_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [7:0]        value;
      logic              last;
      logic              done;
   } entry_type;

   entry_type          mem [FIFO_DEPTH];
   entry_type          ent0, ent1;
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, wr_nxt, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;
   logic               pop;

   assign ent0 = '{address: plan.addr0, value: plan.hi0 ? hi_value : lo_value,
                   last: (plan.cnt == 2'd1), done: plan.done};
   assign ent1 = '{address: plan.addr1, value: plan.hi1 ? hi_value : lo_value,
                   last: 1'b1, done: plan.done};

   assign wr_nxt    = wr_ptr_ff + FIFO_AW'(1);
   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(plan.cnt);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
   assign cnt_in    = cnt_ff + (FIFO_AW+1)'(plan.cnt) - (FIFO_AW+1)'(pop);

   // leave space for the plan in flight plus a full two-write item
   assign room = (cnt_ff + (FIFO_AW+1)'(plan.cnt)) <= (FIFO_AW+1)'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (plan.cnt != 2'd0) begin
         mem[wr_ptr_ff] <= ent0;
      end
      if (plan.cnt == 2'd2) begin
         mem[wr_nxt] <= ent1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign rsp_valid        = cnt_ff != '0;
   assign rsp_address      = mem[rd_ptr_ff].address;
   assign rsp_value        = mem[rd_ptr_ff].value;
   assign rsp_last         = mem[rd_ptr_ff].last;
   assign rsp_capture_done = mem[rd_ptr_ff].done;

endmodule

// ----- rtl/adc_sample_calibrate_decimate.sv -----
// ADC sample calibrate and decimate, top level: CSR file, two calibration lanes,
// sequencer and merge queue. Depends on asc_pkg, asc_cal_lane, asc_sequencer, asc_merge.
// Each item's plan is registered in the sequencer, then its writes queue for rsp.
// Throughput: one item per cycle while items yield at most one write and rsp_ready
// is high; the single result port takes one write per cycle, so two-write items stall.
// Reset (synchronous): registers take their defaults, capture idle, result queue empty.
module adc_sample_calibrate_decimate (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_cmd,
   input  logic [7:0]                 req_low_byte,
   input  logic [7:0]                 req_high_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [asc_pkg::ADDR_W-1:0] rsp_address,
   output logic [7:0]                 rsp_value,
   output logic                       rsp_last,
   output logic                       rsp_capture_done,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [4:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import asc_pkg::*;

   cfg_type           cfg_ff;
   plan_type          plan;
   logic [2:0]        reg_idx;
   logic              csr_wr, accept, room;
   logic signed [9:0] lo_sample, hi_sample;
   logic [7:0]        lo_value, hi_value;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= MODE_NORMAL;
         cfg_ff.stride       <= 8'd1;
         cfg_ff.start_offset <= '0;
         cfg_ff.point_count  <= PCOUNT_W'(BUF_POINTS);
         cfg_ff.midpoint     <= 8'd128;
         cfg_ff.gain         <= 16'd16384;
         cfg_ff.balance      <= '0;
         cfg_ff.odd_start    <= 1'b0;
      end else if (csr_wr) begin
         case (reg_idx)
            REG_MODE:      cfg_ff.mode         <= csr_pwdata[2:0];
            REG_STRIDE:    cfg_ff.stride       <= csr_pwdata[7:0];
            REG_START_OFS: cfg_ff.start_offset <= signed'(csr_pwdata[10:0]);
            REG_PCOUNT:    cfg_ff.point_count  <= csr_pwdata[PCOUNT_W-1:0];
            REG_MIDPOINT:  cfg_ff.midpoint     <= csr_pwdata[7:0];
            REG_GAIN:      cfg_ff.gain         <= csr_pwdata[15:0];
            REG_BALANCE:   cfg_ff.balance      <= signed'(csr_pwdata[7:0]);
            REG_ODD_START: cfg_ff.odd_start    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:      csr_prdata = 32'(cfg_ff.mode);
         REG_STRIDE:    csr_prdata = 32'(cfg_ff.stride);
         REG_START_OFS: csr_prdata = 32'(unsigned'(cfg_ff.start_offset));
         REG_PCOUNT:    csr_prdata = 32'(cfg_ff.point_count);
         REG_MIDPOINT:  csr_prdata = 32'(cfg_ff.midpoint);
         REG_GAIN:      csr_prdata = 32'(cfg_ff.gain);
         REG_BALANCE:   csr_prdata = 32'(unsigned'(cfg_ff.balance));
         REG_ODD_START: csr_prdata = 32'(cfg_ff.odd_start);
         default:       csr_prdata = '0;
      endcase
   end

   assign req_ready = room;
   assign accept    = req_valid && req_ready;

   // balance applies to the high byte only
   assign lo_sample = signed'({2'b00, req_low_byte});
   assign hi_sample = signed'({2'b00, req_high_byte})
                    + {{2{cfg_ff.balance[7]}}, cfg_ff.balance};

   asc_cal_lane u_lane_lo (
      .clock    (clock),
      .load     (accept),
      .sample   (lo_sample),
      .midpoint (cfg_ff.midpoint),
      .gain     (cfg_ff.gain),
      .value    (lo_value)
   );

   asc_cal_lane u_lane_hi (
      .clock    (clock),
      .load     (accept),
      .sample   (hi_sample),
      .midpoint (cfg_ff.midpoint),
      .gain     (cfg_ff.gain),
      .value    (hi_value)
   );

   asc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cmd    (req_cmd),
      .cfg    (cfg_ff),
      .plan   (plan)
   );

   asc_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .plan             (plan),
      .lo_value         (lo_value),
      .hi_value         (hi_value),
      .room             (room),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_address      (rsp_address),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .rsp_capture_done (rsp_capture_done)
   );

endmodule

// ----- verif/adc_sample_calibrate_decimate_test.sv -----
// Self-checking testbench for adc_sample_calibrate_decimate: directed and random
// captures, a local calibration/decimation predictor and an in-order write checker.
// Depends on asc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module adc_sample_calibrate_decimate_test;
   import asc_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [2:0] MODE_UNUSED = 3'd5;
   localparam int ITEM_BUDGET = 1850;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [7:0]        value;
      logic              last;
      logic              done;
   } buf_write_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_cmd;
   logic [7:0]          req_low_byte;
   logic [7:0]          req_high_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [ADDR_W-1:0]   rsp_address;
   logic [7:0]          rsp_value;
   logic                rsp_last;
   logic                rsp_capture_done;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [4:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // predictor state and register shadow
   cfg_type       shadow_cfg;
   int            write_pos;
   bit            drop_first;
   bit            lead_high_due;
   int            group_slot;
   bit            capturing;
   buf_write_type item_writes[$];
   buf_write_type pending_writes[$];

   int errors;
   int counted_words;
   int feed_level;
   int drain_level;

   adc_sample_calibrate_decimate u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_low_byte     (req_low_byte),
      .req_high_byte    (req_high_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_address      (rsp_address),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .rsp_capture_done (rsp_capture_done),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait(input int level);
      case (level)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
         default: return int'($urandom_range(0, 17));
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return shadow_cfg.midpoint + 8'($urandom_range(0, 6)) - 8'd3;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] calibrate_code(input int code);
      int delta;
      int mag;
      int scaled;
      int res;
      delta  = code - int'(shadow_cfg.midpoint);
      mag    = (delta < 0) ? -delta : delta;
      // Q2.14 product, truncated toward zero
      scaled = (mag * int'(shadow_cfg.gain)) >>> 14;
      res    = int'(shadow_cfg.midpoint) + ((delta < 0) ? -scaled : scaled);
      if (res < 0) res = 0;
      if (res > 255) res = 255;
      return res[7:0];
   endfunction

   // queue a write for the current item; out-of-range positions produce none
   function automatic void plan_write(input int pos, input int buf_end, input logic [7:0] val);
      buf_write_type w;
      if (pos >= 0 && pos < buf_end) begin
         w.address = pos[ADDR_W-1:0];
         w.value   = val;
         w.last    = 1'b0;
         w.done    = 1'b0;
         item_writes.push_back(w);
      end
   endfunction

   // advance the predictor by one item; returns 1 if the item was not simply ignored
   function automatic bit predict_item(input logic [1:0] cmd, input logic [7:0] lo_raw,
                                       input logic [7:0] hi_raw);
      int buf_end;
      int step;
      int grp;
      logic [7:0] lo_cal;
      logic [7:0] hi_cal;
      buf_end = (shadow_cfg.point_count < BUF_POINTS) ? int'(shadow_cfg.point_count)
                                                      : BUF_POINTS;
      step = int'(shadow_cfg.stride);
      item_writes.delete();
      if (cmd == CMD_START) begin
         write_pos     = (shadow_cfg.mode == MODE_PEAK) ? 0
                                                        : int'($signed(shadow_cfg.start_offset));
         drop_first    = 1'b1;
         lead_high_due = (shadow_cfg.mode == MODE_NORMAL) && !shadow_cfg.odd_start;
         group_slot    = 0;
         capturing     = 1'b1;
         return 1'b1;
      end
      if (cmd == CMD_STOP) begin
         capturing = 1'b0;
         return 1'b1;
      end
      if (cmd != CMD_SAMPLE || !capturing) return 1'b0;
      if (drop_first) begin
         drop_first = 1'b0;
         return 1'b1;
      end
      lo_cal = calibrate_code(int'(lo_raw));
      hi_cal = calibrate_code(int'(hi_raw) + int'($signed(shadow_cfg.balance)));
      case (shadow_cfg.mode)
         MODE_PEAK: begin
            if (write_pos < buf_end) begin
               plan_write(write_pos, buf_end, lo_cal);
               plan_write(write_pos + 1, buf_end, hi_cal);
               write_pos += 2;
            end
         end
         MODE_NORMAL: begin
            if (lead_high_due) begin
               lead_high_due = 1'b0;
               plan_write(write_pos, buf_end, hi_cal);
               write_pos += step;
            end else if (write_pos < buf_end) begin
               plan_write(write_pos, buf_end, lo_cal);
               write_pos += step;
               plan_write(write_pos, buf_end, hi_cal);
               write_pos += step;
            end
         end
         MODE_RAND: begin
            // skip words until the position turns non-negative
            if (write_pos < 0) begin
               write_pos += step;
            end else if (write_pos < buf_end) begin
               plan_write(write_pos, buf_end, lo_cal);
               write_pos += step;
            end
         end
         MODE_DEC4: begin
            if ((group_slot % 2) != 0) begin
               group_slot = 0;
            end else if (write_pos < buf_end) begin
               plan_write(write_pos, buf_end, lo_cal);
               write_pos += step;
               group_slot = 1;
            end
         end
         MODE_DEC5: begin
            grp = group_slot % 5;
            if (grp == 0) begin
               if (write_pos < buf_end) begin
                  plan_write(write_pos, buf_end, lo_cal);
                  write_pos += step;
                  group_slot = 1;
               end else begin
                  group_slot = 0;
               end
            end else begin
               if (grp == 2 && write_pos < buf_end) begin
                  plan_write(write_pos, buf_end, hi_cal);
                  write_pos += step;
               end
               group_slot = (grp == 4) ? 0 : grp + 1;
            end
         end
         default: ;
      endcase
      foreach (item_writes[k]) begin
         item_writes[k].last = (k == item_writes.size() - 1);
         item_writes[k].done = (write_pos >= buf_end);
         pending_writes.push_back(item_writes[k]);
      end
      return 1'b1;
   endfunction

   // call at a rising edge; returns at the edge where the item was accepted, valid held
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] lo, input logic [7:0] hi);
      int gap;
      gap = draw_wait(feed_level);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_low_byte  <= lo;
      req_high_byte <= hi;
      do @(posedge clock); while (!req_ready);
      if (predict_item(cmd, lo, hi)) counted_words++;
   endtask

   // drop valid, let every expected write drain, then cover the block's latency
   task automatic wait_idle();
      int spin;
      req_valid <= 1'b0;
      spin = 0;
      while (pending_writes.size() != 0 && spin < 2000) begin
         @(posedge clock);
         spin++;
      end
      if (pending_writes.size() != 0) begin
         $display("%0t: write to %0d value %0d expected, none arrived (%0d left)", $time,
                  pending_writes[0].address, pending_writes[0].value, pending_writes.size());
         errors++;
         pending_writes.delete();
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MODE:      shadow_cfg.mode         = data[2:0];
         REG_STRIDE:    shadow_cfg.stride       = data[7:0];
         REG_START_OFS: shadow_cfg.start_offset = data[10:0];
         REG_PCOUNT:    shadow_cfg.point_count  = data[PCOUNT_W-1:0];
         REG_MIDPOINT:  shadow_cfg.midpoint     = data[7:0];
         REG_GAIN:      shadow_cfg.gain         = data[15:0];
         REG_BALANCE:   shadow_cfg.balance      = data[7:0];
         REG_ODD_START: shadow_cfg.odd_start    = data[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic randomize_config(input bit deep);
      logic [31:0] pick;
      write_reg(REG_MODE, ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                      : $urandom_range(0, 4));
      case ($urandom_range(0, 9))
         0: pick = 32'd0;
         1: pick = 32'd255;
         2, 3, 4, 5: pick = $urandom_range(1, 4);
         default: pick = $urandom_range(1, 255);
      endcase
      write_reg(REG_STRIDE, pick);
      case ($urandom_range(0, 7))
         0: pick = 32'h400;
         1: pick = 32'd1023;
         2: pick = 32'd0;
         3, 4: pick = $urandom_range(0, 60) - 30;
         default: pick = $urandom_range(0, 2047);
      endcase
      write_reg(REG_START_OFS, pick);
      if (deep) begin
         case ($urandom_range(0, 3))
            0: pick = 32'd1024;
            1: pick = 32'd2047;
            default: pick = $urandom_range(512, 2047);
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0: pick = 32'd0;
            1: pick = 32'd1;
            default: pick = $urandom_range(1, 48);
         endcase
      end
      write_reg(REG_PCOUNT, pick);
      case ($urandom_range(0, 7))
         0: pick = 32'd0;
         1: pick = 32'd255;
         default: pick = $urandom_range(0, 255);
      endcase
      write_reg(REG_MIDPOINT, pick);
      case ($urandom_range(0, 7))
         0: pick = 32'd0;
         1: pick = 32'hFFFF;
         2, 3: pick = 32'd16384;
         default: pick = $urandom_range(0, 65535);
      endcase
      write_reg(REG_GAIN, pick);
      case ($urandom_range(0, 7))
         0: pick = 32'h80;
         1: pick = 32'h7F;
         2, 3: pick = 32'd0;
         default: pick = $urandom_range(0, 255);
      endcase
      write_reg(REG_BALANCE, pick);
      write_reg(REG_ODD_START, $urandom_range(0, 1));
   endtask

   // reset values, idle sample, discard, lead high byte, unused command, restart, stop
   task automatic test_default_capture();
      feed_level  = 0;
      drain_level = 1;
      send_word(CMD_SAMPLE, 8'h12, 8'h34);
      send_word(CMD_START, 8'h00, 8'h00);
      send_word(CMD_SAMPLE, 8'hAA, 8'h55);
      send_word(CMD_SAMPLE, 8'h00, 8'hFF);
      send_word(CMD_SAMPLE, 8'hFF, 8'h00);
      send_word(CMD_UNUSED, 8'hFF, 8'hFF);
      send_word(CMD_START, 8'h5A, 8'hA5);
      send_word(CMD_STOP, 8'h00, 8'h00);
      wait_idle();
   endtask

   // full-scale gain, balance and midpoint, with a change in the middle of a capture
   task automatic test_calibration_extremes();
      feed_level  = 1;
      drain_level = 2;
      write_reg(REG_MODE, MODE_PEAK);
      write_reg(REG_GAIN, 32'hFFFF);
      write_reg(REG_BALANCE, 32'h7F);
      write_reg(REG_MIDPOINT, 32'd0);
      send_word(CMD_START, 8'h00, 8'h00);
      send_word(CMD_SAMPLE, 8'h11, 8'h22);
      send_word(CMD_SAMPLE, 8'hFF, 8'hFF);
      wait_idle();
      write_reg(REG_GAIN, 32'd0);
      write_reg(REG_MIDPOINT, 32'd255);
      write_reg(REG_BALANCE, 32'h80);
      send_word(CMD_SAMPLE, 8'h00, 8'hFF);
      wait_idle();
   endtask

   // unused mode, buffer end, zero stride, mode switch while capturing
   task automatic test_special_cases();
      feed_level  = 1;
      drain_level = 1;
      write_reg(REG_GAIN, 32'd16384);
      write_reg(REG_MIDPOINT, 32'd128);
      write_reg(REG_MODE, MODE_UNUSED);
      send_word(CMD_START, 8'h00, 8'h00);
      send_word(CMD_SAMPLE, 8'h01, 8'h02);
      send_word(CMD_SAMPLE, 8'h03, 8'h04);
      wait_idle();
      write_reg(REG_MODE, MODE_PEAK);
      write_reg(REG_PCOUNT, 32'd3);
      send_word(CMD_START, 8'h00, 8'h00);
      send_word(CMD_SAMPLE, 8'h10, 8'h20);
      send_word(CMD_SAMPLE, 8'h01, 8'hFE);
      send_word(CMD_SAMPLE, 8'hFE, 8'h01);
      send_word(CMD_SAMPLE, 8'h7F, 8'h80);
      wait_idle();
      write_reg(REG_MODE, MODE_DEC5);
      write_reg(REG_STRIDE, 32'd0);
      write_reg(REG_PCOUNT, 32'd16);
      send_word(CMD_START, 8'h00, 8'h00);
      send_word(CMD_SAMPLE, 8'h33, 8'h44);
      send_word(CMD_SAMPLE, 8'h90, 8'h60);
      send_word(CMD_SAMPLE, 8'h70, 8'hA0);
      wait_idle();
      write_reg(REG_MODE, MODE_DEC4);
      send_word(CMD_SAMPLE, 8'hC0, 8'h40);
      wait_idle();
      write_reg(REG_MODE, MODE_NORMAL);
      send_word(CMD_SAMPLE, 8'h08, 8'hF8);
      wait_idle();
   endtask

   // mostly well-formed captures with random settings and content, some noise mixed in
   task automatic test_random_captures();
      int target;
      int words;
      int k;
      int r;
      bit deep;
      target = counted_words + ITEM_BUDGET;
      while (counted_words < target) begin
         deep = ($urandom_range(0, 19) == 0);
         randomize_config(deep);
         feed_level  = $urandom_range(0, 2);
         drain_level = $urandom_range(0, 2);
         words = deep ? $urandom_range(150, 500) : $urandom_range(1, 40);
         send_word(CMD_START, rand_byte(), rand_byte());
         // stop early once the item budget is spent
         for (k = 0; k < words && counted_words < target; k++) begin
            r = $urandom_range(0, 49);
            if (r == 0) begin
               send_word(CMD_UNUSED, rand_byte(), rand_byte());
            end else if (r == 1) begin
               send_word(CMD_STOP, rand_byte(), rand_byte());
               send_word(CMD_SAMPLE, rand_byte(), rand_byte());
               send_word(CMD_START, rand_byte(), rand_byte());
            end else if (r == 2) begin
               send_word(CMD_START, rand_byte(), rand_byte());
            end else if (r == 3) begin
               // switch mode with the capture still open
               wait_idle();
               write_reg(REG_MODE, $urandom_range(0, 4));
            end else begin
               send_word(CMD_SAMPLE, rand_byte(), rand_byte());
            end
         end
         if ($urandom_range(0, 1) == 1) send_word(CMD_STOP, rand_byte(), rand_byte());
         wait_idle();
      end
   endtask

   initial begin : rsp_drain
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(drain_level);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin : check_writes
      buf_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: write expected none, got address %0d value %0d", $time,
                     rsp_address, rsp_value);
            errors++;
         end else begin
            want = pending_writes.pop_front();
            if (rsp_address !== want.address) begin
               $display("%0t: address expected %0d got %0d", $time, want.address, rsp_address);
               errors++;
            end
            if (rsp_value !== want.value) begin
               $display("%0t: value expected %0d got %0d", $time, want.value, rsp_value);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b got %0b", $time, want.last, rsp_last);
               errors++;
            end
            if (rsp_capture_done !== want.done) begin
               $display("%0t: capture_done expected %0b got %0b", $time, want.done,
                        rsp_capture_done);
               errors++;
            end
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_START;
      req_low_byte  <= 8'h00;
      req_high_byte <= 8'h00;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      errors        = 0;
      counted_words = 0;
      feed_level    = 0;
      drain_level   = 0;
      shadow_cfg    = '{mode: MODE_NORMAL, stride: 8'd1, start_offset: 11'sd0,
                        point_count: 11'd1024, midpoint: 8'd128, gain: 16'd16384,
                        balance: 8'sd0, odd_start: 1'b0};
      write_pos     = 0;
      drop_first    = 1'b0;
      lead_high_due = 1'b0;
      group_slot    = 0;
      capturing     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_default_capture();
      test_calibration_extremes();
      test_special_cases();
      test_random_captures();
      wait_idle();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- adc_sample_calibrate_decimate.f -----
rtl/asc_pkg.sv
rtl/asc_cal_lane.sv
rtl/asc_sequencer.sv
rtl/asc_merge.sv
rtl/adc_sample_calibrate_decimate.sv
verif/adc_sample_calibrate_decimate_test.sv
